@@ rtl/core/cassette_tape_block_modulator_top_assert.svh @@
// Assertion macros shared by the cassette modulator checker.
// Depends on nothing; included by the checker file only.
`ifndef CASSETTE_TAPE_BLOCK_MODULATOR_TOP_ASSERT_SVH
`define CASSETTE_TAPE_BLOCK_MODULATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CTBM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cassette modulator assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CTBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cassette modulator assertion failed");

`endif

@@ rtl/core/ctbm_pkg.sv @@
// Package of the cassette-tape block modulator: codes, structs and wave tables.
// Depends on nothing; used by the command interface, the registers, the wave core and the top level.
package ctbm_pkg;

    // Command codes carried on the request channel.
    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_BLOCK    = 2'd1,
        OP_DATA     = 2'd2,
        OP_CHECKSUM = 2'd3
    } op_t;

    // Generator segments.
    typedef enum logic [1:0] {
        SEG_IDLE = 2'd0,
        SEG_SYNC = 2'd1,
        SEG_TAIL = 2'd2,
        SEG_BYTE = 2'd3
    } seg_t;

    // Register indexes on the configuration port (address bits 3:2).
    typedef enum logic [1:0] {
        REG_TAIL_LEVEL  = 2'd0,
        REG_TAIL_SLOPE  = 2'd1,
        REG_TAIL_OFFSET = 2'd2
    } reg_idx_t;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [14:0] TAIL_LEVEL_RST  = 15'd15000;
    localparam logic [9:0]  TAIL_SLOPE_RST  = 10'd300;
    localparam logic [12:0] TAIL_OFFSET_RST = 13'd2000;

    // Half-wave magnitude tables, already scaled by 1000.
    localparam int ONE_TAB_LEN  = 7;
    localparam int ZERO_TAB_LEN = 15;
    localparam logic [14:0] ONE_MAG [ONE_TAB_LEN] = '{
        15'd15000, 15'd14000, 15'd13000, 15'd12000, 15'd11000, 15'd10000, 15'd9000
    };
    localparam logic [14:0] ZERO_MAG [ZERO_TAB_LEN] = '{
        15'd19000, 15'd18000, 15'd17000, 15'd16000, 15'd15000, 15'd14000,
        15'd13000, 15'd12000, 15'd11000, 15'd10000, 15'd9000, 15'd8000,
        15'd7000, 15'd6000, 15'd5000
    };

    typedef struct packed {
        op_t        op;
        logic [7:0] byte_value;
        logic [7:0] block_number;
        logic [9:0] sync_count;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               sample_valid;
        logic               accepted;
        logic               idle;
    } res_t;

    typedef struct packed {
        logic [14:0] tail_level;
        logic [9:0]  tail_slope;
        logic [12:0] tail_offset;
    } cfg_t;

    // Short half-wave magnitude; positions past the table hold the last entry.
    function automatic logic [14:0] one_mag(input logic [5:0] pos);
        logic [2:0] idx;
        idx = (pos < 6'(ONE_TAB_LEN)) ? pos[2:0] : 3'(ONE_TAB_LEN - 1);
        return ONE_MAG[idx];
    endfunction

    // Long half-wave magnitude; positions past the table hold the last entry.
    function automatic logic [14:0] zero_mag(input logic [5:0] pos);
        logic [3:0] idx;
        idx = (pos < 6'(ZERO_TAB_LEN)) ? pos[3:0] : 4'(ZERO_TAB_LEN - 1);
        return ZERO_MAG[idx];
    endfunction

    // Apply the polarity to a magnitude.
    function automatic logic signed [15:0] apply_pol(input logic pol, input logic [14:0] mag);
        logic signed [15:0] m;
        m = $signed({1'b0, mag});
        return pol ? -m : m;
    endfunction

    // Clamp an 18-bit signed sum to the 16-bit sample range.
    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'sh7FFF;
        end
        else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end
        else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/ctbm_cmd_if.sv @@
// Command request channel of the cassette modulator.
// Depends on ctbm_pkg.
interface ctbm_cmd_if;
    import ctbm_pkg::*;

    logic       valid;
    logic       ready;
    op_t        op;
    logic [7:0] byte_value;
    logic [7:0] block_number;
    logic [9:0] sync_count;

    modport source (output valid, output op, output byte_value, output block_number,
                    output sync_count, input ready);
    modport sink (input valid, input op, input byte_value, input block_number,
                  input sync_count, output ready);
endinterface

@@ rtl/core/ctbm_res_if.sv @@
// Result channel of the cassette modulator.
// Depends on nothing.
interface ctbm_res_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               sample_valid;
    logic               accepted;
    logic               idle;

    modport source (output valid, output sample, output sample_valid, output accepted,
                    output idle, input ready);
    modport sink (input valid, input sample, input sample_valid, input accepted,
                  input idle, output ready);
endinterface

@@ rtl/core/ctbm_apb_regs.sv @@
// Configuration registers of the cassette modulator behind an APB-style port.
// Depends on ctbm_pkg.
module ctbm_apb_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ctbm_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ctbm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ctbm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output ctbm_pkg::cfg_t                      cfg
);
    import ctbm_pkg::*;

    logic [14:0] tail_level_reg;
    logic [9:0]  tail_slope_reg;
    logic [12:0] tail_offset_reg;
    logic        wr_en;
    reg_idx_t    idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);

    // Register writes in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_level_reg  <= TAIL_LEVEL_RST;
            tail_slope_reg  <= TAIL_SLOPE_RST;
            tail_offset_reg <= TAIL_OFFSET_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_TAIL_LEVEL:  tail_level_reg  <= pwdata[14:0];
                REG_TAIL_SLOPE:  tail_slope_reg  <= pwdata[9:0];
                REG_TAIL_OFFSET: tail_offset_reg <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    // Read mux.
    always_comb
    begin
        case (idx)
            REG_TAIL_LEVEL:  prdata = {17'd0, tail_level_reg};
            REG_TAIL_SLOPE:  prdata = {22'd0, tail_slope_reg};
            REG_TAIL_OFFSET: prdata = {19'd0, tail_offset_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.tail_level  = tail_level_reg;
    assign cfg.tail_slope  = tail_slope_reg;
    assign cfg.tail_offset = tail_offset_reg;
endmodule

@@ rtl/core/ctbm_wave_core.sv @@
// Sequencer state and sample generation of the cassette modulator.
// Depends on ctbm_pkg.
module ctbm_wave_core #(
    parameter int ONE_HALF_SAMPLES  = 7,
    parameter int ZERO_HALF_SAMPLES = 15,
    parameter int TAIL_SAMPLES      = 40
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  ctbm_pkg::cmd_t cmd,
    input  ctbm_pkg::cfg_t cfg,
    output ctbm_pkg::res_t res
);
    import ctbm_pkg::*;

    localparam logic [5:0] ONE_LEN  = 6'(ONE_HALF_SAMPLES);
    localparam logic [5:0] ZERO_LEN = 6'(ZERO_HALF_SAMPLES);
    localparam logic [5:0] TAIL_LEN = 6'(TAIL_SAMPLES);

    logic       pol_reg, pol_next;
    seg_t       seg_reg, seg_next;
    logic [9:0] sync_left_reg, sync_left_next;
    logic [5:0] sample_pos_reg, sample_pos_next;
    logic [2:0] bit_pos_reg, bit_pos_next;
    logic [7:0] shift_byte_reg, shift_byte_next;
    logic [7:0] pending_reg, pending_next;
    logic [7:0] sum_reg, sum_next;

    logic [5:0]          pos_inc;
    logic [9:0]          sync_dec;
    logic [15:0]         tail_ramp;
    logic signed [15:0]  tail_lvl;
    logic signed [17:0]  tail_sum;
    logic signed [15:0]  short_s;
    logic signed [15:0]  long_s;
    logic [5:0]          bit_len;
    logic                busy;

    assign pos_inc   = sample_pos_reg + 6'd1;
    assign sync_dec  = sync_left_reg - 10'd1;
    assign busy      = (seg_reg != SEG_IDLE);
    assign short_s   = apply_pol(pol_reg, one_mag(sample_pos_reg));
    assign long_s    = apply_pol(pol_reg, zero_mag(sample_pos_reg));
    assign bit_len   = shift_byte_reg[7] ? ONE_LEN : ZERO_LEN;

    // Tail ramp: signed level minus position times slope plus offset.
    assign tail_ramp = {10'd0, sample_pos_reg} * {6'd0, cfg.tail_slope};
    assign tail_lvl  = apply_pol(pol_reg, cfg.tail_level);
    assign tail_sum  = $signed({{2{tail_lvl[15]}}, tail_lvl})
                     - $signed({2'b00, tail_ramp})
                     + $signed({5'd0, cfg.tail_offset});

    // Next state and result of one command.
    always_comb
    begin
        pol_next         = pol_reg;
        seg_next         = seg_reg;
        sync_left_next   = sync_left_reg;
        sample_pos_next  = sample_pos_reg;
        bit_pos_next     = bit_pos_reg;
        shift_byte_next  = shift_byte_reg;
        pending_next     = pending_reg;
        sum_next         = sum_reg;
        res.sample       = '0;
        res.sample_valid = 1'b0;
        res.accepted     = 1'b1;

        if (cmd.op == OP_TICK)
        begin
            if (busy)
            begin
                res.sample_valid = 1'b1;
                case (seg_reg)
                    SEG_SYNC:
                    begin
                        res.sample = short_s;
                        if (pos_inc >= ONE_LEN)
                        begin
                            sample_pos_next = '0;
                            pol_next        = ~pol_reg;
                            sync_left_next  = sync_dec;
                            if (sync_dec == 10'd0)
                            begin
                                seg_next = SEG_TAIL;
                            end
                        end
                        else
                        begin
                            sample_pos_next = pos_inc;
                        end
                    end
                    SEG_TAIL:
                    begin
                        res.sample = sat16(tail_sum);
                        if (pos_inc >= TAIL_LEN)
                        begin
                            sample_pos_next = '0;
                            pol_next        = ~pol_reg;
                            shift_byte_next = pending_reg;
                            bit_pos_next    = '0;
                            seg_next        = SEG_BYTE;
                        end
                        else
                        begin
                            sample_pos_next = pos_inc;
                        end
                    end
                    default:
                    begin
                        res.sample = shift_byte_reg[7] ? short_s : long_s;
                        if (pos_inc >= bit_len)
                        begin
                            sample_pos_next = '0;
                            pol_next        = ~pol_reg;
                            shift_byte_next = {shift_byte_reg[6:0], 1'b0};
                            if (bit_pos_reg == 3'd7)
                            begin
                                bit_pos_next = '0;
                                seg_next     = SEG_IDLE;
                            end
                            else
                            begin
                                bit_pos_next = bit_pos_reg + 3'd1;
                            end
                        end
                        else
                        begin
                            sample_pos_next = pos_inc;
                        end
                    end
                endcase
            end
        end
        else if (busy)
        begin
            res.accepted = 1'b0;
        end
        else
        begin
            sample_pos_next = '0;
            bit_pos_next    = '0;
            case (cmd.op)
                OP_BLOCK:
                begin
                    sync_left_next = cmd.sync_count;
                    pending_next   = cmd.block_number;
                    sum_next       = '0;
                    seg_next       = (cmd.sync_count != 10'd0) ? SEG_SYNC : SEG_TAIL;
                end
                OP_DATA:
                begin
                    shift_byte_next = cmd.byte_value;
                    sum_next        = sum_reg + cmd.byte_value;
                    seg_next        = SEG_BYTE;
                end
                default:
                begin
                    shift_byte_next = sum_reg;
                    seg_next        = SEG_BYTE;
                end
            endcase
        end

        res.idle = (seg_next == SEG_IDLE);
    end

    // State registers advance once per processed command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pol_reg        <= 1'b0;
            seg_reg        <= SEG_IDLE;
            sync_left_reg  <= '0;
            sample_pos_reg <= '0;
            bit_pos_reg    <= '0;
            shift_byte_reg <= '0;
            pending_reg    <= '0;
            sum_reg        <= '0;
        end
        else if (step)
        begin
            pol_reg        <= pol_next;
            seg_reg        <= seg_next;
            sync_left_reg  <= sync_left_next;
            sample_pos_reg <= sample_pos_next;
            bit_pos_reg    <= bit_pos_next;
            shift_byte_reg <= shift_byte_next;
            pending_reg    <= pending_next;
            sum_reg        <= sum_next;
        end
    end
endmodule

@@ rtl/core/cassette_tape_block_modulator_top.sv @@
// A request goes into the input register, then through the sequencer logic into the result
// register, from which its result is presented.
// Throughput: one request and one sequencer command per cycle, unless a result stalls.
// A stalled result holds in the result register; the input register takes one more request.
// Reset (rst_n low, asynchronous) clears the valid flags of both stages and the sequencer
// state, and loads the default tail registers; polarity starts positive.
module cassette_tape_block_modulator_top #(
    parameter int ONE_HALF_SAMPLES  = 7,
    parameter int ZERO_HALF_SAMPLES = 15,
    parameter int TAIL_SAMPLES      = 40
) (
    input  logic                            clk,
    input  logic                            rst_n,
    ctbm_cmd_if.sink                        cmd,
    ctbm_res_if.source                      res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ctbm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ctbm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ctbm_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import ctbm_pkg::*;

    cfg_t cfg;
    cmd_t in_cmd;
    cmd_t s1_cmd_reg;
    logic s1_valid_reg, s1_valid_next;
    res_t core_res;
    res_t out_res_reg;
    logic out_valid_reg, out_valid_next;
    logic advance;
    logic take;

    ctbm_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ctbm_wave_core #(
        .ONE_HALF_SAMPLES  (ONE_HALF_SAMPLES),
        .ZERO_HALF_SAMPLES (ZERO_HALF_SAMPLES),
        .TAIL_SAMPLES      (TAIL_SAMPLES)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .cmd   (s1_cmd_reg),
        .cfg   (cfg),
        .res   (core_res)
    );

    // Handshake: the input stage moves on whenever the result register is free or drained.
    assign advance   = s1_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready = !s1_valid_reg || advance;
    assign take      = cmd.valid && cmd.ready;

    assign in_cmd.op           = cmd.op;
    assign in_cmd.byte_value   = cmd.byte_value;
    assign in_cmd.block_number = cmd.block_number;
    assign in_cmd.sync_count   = cmd.sync_count;

    // Stage valid flags.
    always_comb
    begin
        s1_valid_next = take ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        out_valid_next = advance ? 1'b1 : (res.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_cmd_reg <= in_cmd;
        end
        if (advance)
        begin
            out_res_reg <= core_res;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.sample       = out_res_reg.sample;
    assign res.sample_valid = out_res_reg.sample_valid;
    assign res.accepted     = out_res_reg.accepted;
    assign res.idle         = out_res_reg.idle;
endmodule

@@ rtl/core/ctbm_checker.sv @@
// Port-level checks of the cassette modulator, bound to the top level.
// Depends on cassette_tape_block_modulator_top_assert.svh.
module ctbm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [15:0] res_sample,
    input logic        res_sample_valid,
    input logic        res_accepted,
    input logic        res_idle
);
`include "cassette_tape_block_modulator_top_assert.svh"

    // A result without a waveform sample carries a zero sample.
    `CTBM_ASSERT_NOW(a_zero_sample, clk, rst_n, res_valid && !res_sample_valid, res_sample == 16'd0)

    // A waveform sample only comes from a taken tick.
    `CTBM_ASSERT_NOW(a_sample_taken, clk, rst_n, res_valid && res_sample_valid, res_accepted)

    // A rejected command means the generator was busy and stays busy.
    `CTBM_ASSERT_NOW(a_reject_busy, clk, rst_n, res_valid && !res_accepted, !res_idle)

    // A stalled result stays put.
    `CTBM_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_sample) && $stable(res_idle))
endmodule

bind cassette_tape_block_modulator_top ctbm_checker u_ctbm_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_valid        (res.valid),
    .res_ready        (res.ready),
    .res_sample       (res.sample),
    .res_sample_valid (res.sample_valid),
    .res_accepted     (res.accepted),
    .res_idle         (res.idle)
);
